// ----- design/mm4_pkg.sv -----
// package: constants and controller/datapath interface types for the 4x4 matrix multiplier
`timescale 1ns / 1ps

package mm4_pkg;

	// matrix geometry
	localparam int DIM       = 4;
	localparam int CELLS     = DIM * DIM;
	localparam int DIM_W     = $clog2(DIM);
	localparam int IDX_W     = $clog2(CELLS);

	// fixed point format
	localparam int DATA_W    = 32;
	localparam int FRAC_BITS = 16;
	localparam int PROD_W    = 2 * DATA_W;
	localparam int PAIR_W    = PROD_W + 1;
	localparam int SUM_W     = PROD_W + 2;

	localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};
	localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(CELLS - 1);

	// controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN
	} state_t;

	// controller to datapath commands
	typedef struct packed {
		logic             load;
		logic             issue;
		logic [IDX_W-1:0] idx;
		logic             last;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic adv;
		logic busy;
	} status_t;

endpackage

// ----- design/mm4_ctrl.sv -----
// controller: load acceptance, result index sequencing and pipeline drain
`timescale 1ns / 1ps

module mm4_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              last_load,
	input  mm4_pkg::status_t  sts,
	output logic              in_stall,
	output mm4_pkg::cmd_t     cmd
);
	import mm4_pkg::*;

	state_t             state_q, state_d;
	logic [IDX_W-1:0]   idx_q, idx_d;

	// state and index registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d   = state_q;
		idx_d     = idx_q;
		in_stall  = (state_q != ST_IDLE);
		cmd.load  = 1'b0;
		cmd.issue = 1'b0;
		cmd.idx   = idx_q;
		cmd.last  = (idx_q == LAST_IDX);
		case (state_q)
			ST_IDLE: begin
				cmd.load = in_valid;
				if (in_valid && last_load) begin
					state_d = ST_RUN;
					idx_d   = '0;
				end
			end
			ST_RUN: begin
				if (sts.adv) begin
					cmd.issue = 1'b1;
					if (idx_q == LAST_IDX) begin
						state_d = ST_DRAIN;
					end else begin
						idx_d = idx_q + 1'b1;
					end
				end
			end
			ST_DRAIN: begin
				if (!sts.busy) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ----- design/mm4_dpath.sv -----
// datapath: banked element stores, four multiply lanes, adder tree, shift and saturate
`timescale 1ns / 1ps

module mm4_dpath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  mm4_pkg::cmd_t                     cmd,
	output mm4_pkg::status_t                  sts,
	input  logic signed [mm4_pkg::DATA_W-1:0] left_value,
	input  logic signed [mm4_pkg::DATA_W-1:0] right_value,
	input  logic        [mm4_pkg::IDX_W-1:0]  position,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [mm4_pkg::DATA_W-1:0] product_value,
	output logic        [mm4_pkg::IDX_W-1:0]  product_position,
	output logic                              last_result,
	output logic                              saturated
);
	import mm4_pkg::*;

	// bank k of the left store holds column k, bank k of the right store holds row k
	logic signed [DATA_W-1:0] left_mem  [DIM][DIM];
	logic signed [DATA_W-1:0] right_mem [DIM][DIM];

	logic                     v_s1, v_s2, v_s3, v_s4;
	logic [IDX_W-1:0]         pos_s1, pos_s2, pos_s3, pos_s4;
	logic                     last_s1, last_s2, last_s3, last_s4;
	logic signed [DATA_W-1:0] left_s1  [DIM];
	logic signed [DATA_W-1:0] right_s1 [DIM];
	logic signed [PROD_W-1:0] prod_s2  [DIM];
	logic signed [PAIR_W-1:0] pair_s3  [DIM/2];
	logic signed [SUM_W-1:0]  sum_s4;

	logic                     adv;
	logic [DIM_W-1:0]         wr_row, wr_col, rd_row, rd_col;
	logic signed [SUM_W-1:0]  shifted;
	logic                     sat_hi, sat_lo;

	// whole pipeline moves unless the output beat is held
	assign adv      = !out_valid || !out_stall;
	assign sts.adv  = adv;
	assign sts.busy = v_s1 || v_s2 || v_s3 || v_s4;

	assign wr_row = position[IDX_W-1:DIM_W];
	assign wr_col = position[DIM_W-1:0];
	assign rd_row = cmd.idx[IDX_W-1:DIM_W];
	assign rd_col = cmd.idx[DIM_W-1:0];

	// store writes and registered lane reads
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			left_mem[wr_col][wr_row]  <= left_value;
			right_mem[wr_row][wr_col] <= right_value;
		end
		if (adv) begin
			for (int k = 0; k < DIM; k++) begin
				left_s1[k]  <= left_mem[k][rd_row];
				right_s1[k] <= right_mem[k][rd_col];
			end
		end
	end

	// pipeline valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			v_s4      <= 1'b0;
			out_valid <= 1'b0;
		end else if (adv) begin
			v_s1      <= cmd.issue;
			v_s2      <= v_s1;
			v_s3      <= v_s2;
			v_s4      <= v_s3;
			out_valid <= v_s4;
		end
	end

	// rounding toward minus infinity, then range check on the upper bits
	assign shifted = sum_s4 >>> FRAC_BITS;
	assign sat_hi  = !shifted[SUM_W-1] && (|shifted[SUM_W-2:DATA_W-1]);
	assign sat_lo  = shifted[SUM_W-1] && !(&shifted[SUM_W-2:DATA_W-1]);

	// multiply lanes, adder tree and output register
	always_ff @(posedge clk) begin
		if (adv) begin
			pos_s1  <= cmd.idx;
			last_s1 <= cmd.last;
			for (int k = 0; k < DIM; k++) begin
				prod_s2[k] <= left_s1[k] * right_s1[k];
			end
			pos_s2  <= pos_s1;
			last_s2 <= last_s1;
			for (int j = 0; j < DIM/2; j++) begin
				pair_s3[j] <= PAIR_W'(prod_s2[2*j]) + PAIR_W'(prod_s2[2*j+1]);
			end
			pos_s3  <= pos_s2;
			last_s3 <= last_s2;
			sum_s4  <= SUM_W'(pair_s3[0]) + SUM_W'(pair_s3[1]);
			pos_s4  <= pos_s3;
			last_s4 <= last_s3;
			if (sat_hi) begin
				product_value <= SAT_MAX;
			end else if (sat_lo) begin
				product_value <= SAT_MIN;
			end else begin
				product_value <= shifted[DATA_W-1:0];
			end
			saturated        <= sat_hi || sat_lo;
			product_position <= pos_s4;
			last_result      <= last_s4;
		end
	end

endmodule

// ----- design/matrix4x4_multiply.sv -----
// top level: 4x4 signed Q16.16 matrix multiplier
//
// channel  | direction | handshake           | payload
// ---------+-----------+---------------------+----------------------------------------------
// load     | in        | in_valid, in_stall  | left_value, right_value, position, last_load
// result   | out       | out_valid, out_stall| product_value, product_position, last_result,
//          |           |                     | saturated
//
// a beat with last_load starts a run of 16 result beats; each result goes through the
// lane read, multiply, pair add and final sum registers, then the output register.
// results leave one per cycle while out_stall is low, one dot product per cycle from the
// four multiply lanes and the per-lane store banks. in_stall goes high once the last load
// beat is accepted and stays high until the final element has left the adder tree.
// out_stall with out_valid freezes the pipeline, store reads included; no beat is lost.
// reset clears control state only; store contents are undefined until written.
`timescale 1ns / 1ps

module matrix4x4_multiply (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [mm4_pkg::DATA_W-1:0] left_value,
	input  logic signed [mm4_pkg::DATA_W-1:0] right_value,
	input  logic        [mm4_pkg::IDX_W-1:0]  position,
	input  logic                              last_load,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [mm4_pkg::DATA_W-1:0] product_value,
	output logic        [mm4_pkg::IDX_W-1:0]  product_position,
	output logic                              last_result,
	output logic                              saturated
);
	import mm4_pkg::*;

	cmd_t    cmd;
	status_t sts;

	// sequencing
	mm4_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.last_load (last_load),
		.sts       (sts),
		.in_stall  (in_stall),
		.cmd       (cmd)
	);

	// arithmetic and storage
	mm4_dpath u_dpath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.left_value       (left_value),
		.right_value      (right_value),
		.position         (position),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.product_value    (product_value),
		.product_position (product_position),
		.last_result      (last_result),
		.saturated        (saturated)
	);

	// a run start blocks further load beats
	a_last_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && last_load |=> in_stall)
		else $error("load beat accepted right after run start");

	// results only come out of a run that held the load side
	a_out_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result beat without a run");

	// the flagged result is the final element
	a_last_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_result |-> product_position == LAST_IDX)
		else $error("last result flag on wrong element");

	// saturated values are clipped to the range limits
	a_sat_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |-> product_value == SAT_MAX || product_value == SAT_MIN)
		else $error("saturated element not at a range limit");

endmodule

// ----- tb/sv/matrix4x4_multiply_checker.sv -----
// checker: predicts the q16.16 matrix product and compares every result beat
`timescale 1ns / 1ps

module matrix4x4_multiply_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic                              in_stall,
	input  logic signed [mm4_pkg::DATA_W-1:0] left_value,
	input  logic signed [mm4_pkg::DATA_W-1:0] right_value,
	input  logic        [mm4_pkg::IDX_W-1:0]  position,
	input  logic                              last_load,
	input  logic                              out_valid,
	input  logic                              out_stall,
	input  logic signed [mm4_pkg::DATA_W-1:0] product_value,
	input  logic        [mm4_pkg::IDX_W-1:0]  product_position,
	input  logic                              last_result,
	input  logic                              saturated,
	output int                                mismatches,
	output int                                products_owed
);

	import mm4_pkg::*;

	localparam int REPORT_LIMIT = 10;

	// one element of the product matrix
	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic        [IDX_W-1:0]  index;
		logic                     last;
		logic                     clipped;
	} product_t;

	// local copy of both operand matrices
	logic signed [DATA_W-1:0] left_cells [CELLS];
	logic signed [DATA_W-1:0] right_cells [CELLS];

	product_t owed_products [$];
	product_t head;
	int       mismatch_count = 0;
	int       owed_count = 0;

	assign mismatches    = mismatch_count;
	assign products_owed = owed_count;

	// exact dot product, floor shift, then clip to 32 bits
	function automatic product_t product_element(input int row, input int col);
		logic signed [SUM_W-1:0] acc;
		logic signed [SUM_W-1:0] lhs;
		logic signed [SUM_W-1:0] rhs;
		logic signed [SUM_W-1:0] scaled;
		product_t                elem;
		acc = '0;
		for (int k = 0; k < DIM; k++) begin
			lhs = SUM_W'(left_cells[row * DIM + k]);
			rhs = SUM_W'(right_cells[k * DIM + col]);
			acc = acc + lhs * rhs;
		end
		scaled = acc >>> FRAC_BITS;
		elem.index = IDX_W'(row * DIM + col);
		elem.last  = (row * DIM + col == CELLS - 1);
		// fits when every bit above the sign position matches the sign
		if (&scaled[SUM_W-1:DATA_W-1] || ~|scaled[SUM_W-1:DATA_W-1]) begin
			elem.value   = scaled[DATA_W-1:0];
			elem.clipped = 1'b0;
		end else begin
			elem.value   = scaled[SUM_W-1] ? SAT_MIN : SAT_MAX;
			elem.clipped = 1'b1;
		end
		return elem;
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			// result beat against the oldest owed element
			if (out_valid && !out_stall) begin
				if (owed_products.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_LIMIT)
						$display("%0t: result beat with nothing owed: %h pos %0d last %b sat %b",
							$time, product_value, product_position, last_result, saturated);
				end else begin
					head = owed_products.pop_front();
					if (head.value !== product_value || head.index !== product_position ||
						head.last !== last_result || head.clipped !== saturated) begin
						mismatch_count++;
						if (mismatch_count <= REPORT_LIMIT)
							$display("%0t: exp/act value %h/%h pos %0d/%0d last %b/%b sat %b/%b",
								$time, head.value, product_value,
								head.index, product_position, head.last, last_result,
								head.clipped, saturated);
					end
				end
			end
			// load beat updates the stores, a last beat owes a full matrix
			if (in_valid && !in_stall) begin
				left_cells[position]  = left_value;
				right_cells[position] = right_value;
				if (last_load) begin
					for (int r = 0; r < DIM; r++)
						for (int c = 0; c < DIM; c++)
							owed_products.push_back(product_element(r, c));
				end
			end
			owed_count <= owed_products.size();
		end
	end

endmodule

// ----- tb/sv/tb_matrix4x4_multiply.sv -----
// testbench top: drives load beats and result stalls, reports the verdict
`timescale 1ns / 1ps

module tb_matrix4x4_multiply;

	import mm4_pkg::*;

	localparam int                STALL_PCT      = 32;
	localparam int                ITEMS          = 410;
	localparam int                WATCHDOG_LIMIT = 2000;
	localparam int                DRAIN_CYCLES   = 40;
	localparam logic [DATA_W-1:0] Q_ONE          = 32'h0001_0000;
	localparam logic [DATA_W-1:0] Q_NEG_ONE      = 32'hFFFF_0000;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	logic signed [DATA_W-1:0] left_value = '0;
	logic signed [DATA_W-1:0] right_value = '0;
	logic        [IDX_W-1:0]  position = '0;
	logic                     last_load = 1'b0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic signed [DATA_W-1:0] product_value;
	logic        [IDX_W-1:0]  product_position;
	logic                     last_result;
	logic                     saturated;
	logic                     quiet = 1'b0;

	int mismatches;
	int products_owed;
	int loads_sent = 0;
	int runs_sent = 0;
	int results_seen = 0;
	int clipped_seen = 0;
	int idle_cycles = 0;

	matrix4x4_multiply dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.left_value       (left_value),
		.right_value      (right_value),
		.position         (position),
		.last_load        (last_load),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.product_value    (product_value),
		.product_position (product_position),
		.last_result      (last_result),
		.saturated        (saturated)
	);

	matrix4x4_multiply_checker checker_i (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.left_value       (left_value),
		.right_value      (right_value),
		.position         (position),
		.last_load        (last_load),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.product_value    (product_value),
		.product_position (product_position),
		.last_result      (last_result),
		.saturated        (saturated),
		.mismatches       (mismatches),
		.products_owed    (products_owed)
	);

	always #5 clk = ~clk;

	// random result-side stall, off during the quiet stretch
	always @(posedge clk) begin
		out_stall <= !quiet && ($urandom_range(99) < STALL_PCT);
	end

	// watchdog on cycles with no beat on either side, plus result tallies
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (arst_n && out_valid && !out_stall) begin
			results_seen <= results_seen + 1;
			if (saturated)
				clipped_seen <= clipped_seen + 1;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL matrix4x4_multiply");
			$finish;
		end
	end

	// one load beat, then maybe a random gap
	task automatic load_beat(input logic [DATA_W-1:0] lv, input logic [DATA_W-1:0] rv,
		input int pos, input logic last);
		in_valid    <= 1'b1;
		left_value  <= lv;
		right_value <= rv;
		position    <= IDX_W'(pos);
		last_load   <= last;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		loads_sent++;
		if (last)
			runs_sent++;
		if (!quiet && $urandom_range(99) < STALL_PCT) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < STALL_PCT);
		end
	endtask

	// mostly small operands, some wide, some full range, some corner values
	function automatic logic [DATA_W-1:0] random_element();
		int pick;
		pick = $urandom_range(99);
		if (pick < 50)
			return $urandom_range(32'h0007_FFFF) - 32'h0004_0000;
		if (pick < 65)
			return $urandom_range(32'h01FF_FFFF) - 32'h0100_0000;
		if (pick < 90)
			return $urandom;
		case ($urandom_range(6))
			0:       return SAT_MIN;
			1:       return SAT_MAX;
			2:       return '0;
			3:       return '1;
			4:       return 32'd1;
			5:       return Q_ONE;
			default: return Q_NEG_ONE;
		endcase
	endfunction

	initial begin : stimulus
		logic [DATA_W-1:0] lv;
		logic [DATA_W-1:0] rv;
		int                run_len;
		bit                drained;
		drained = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fill every cell: rows of min, max, one and a mix of tiny values and minus one against
		// columns of min, max, one and minus one, so both clip directions show
		for (int p = 0; p < CELLS; p++) begin
			case (p / DIM)
				0:       lv = SAT_MIN;
				1:       lv = SAT_MAX;
				2:       lv = Q_ONE;
				default: begin
					case (p % DIM)
						0:       lv = '1;
						1:       lv = 32'd1;
						2:       lv = '0;
						default: lv = Q_NEG_ONE;
					endcase
				end
			endcase
			case (p % DIM)
				0:       rv = SAT_MIN;
				1:       rv = SAT_MAX;
				2:       rv = Q_ONE;
				default: rv = Q_NEG_ONE;
			endcase
			load_beat(lv, rv, p, p == CELLS - 1);
		end
		// floor rounding of tiny negative products, a one-beat run, an extreme pair
		load_beat('1, 32'd1, 3, 1'b0);
		load_beat(32'd1, '1, 12, 1'b1);
		load_beat('0, '0, 15, 1'b1);
		load_beat(SAT_MAX, SAT_MIN, 6, 1'b1);

		// random runs of partial reloads; stores are full so any position is safe
		while (loads_sent < ITEMS) begin
			if ($urandom_range(9) == 0)
				run_len = CELLS;
			else if ($urandom_range(4) == 0)
				run_len = 1;
			else
				run_len = $urandom_range(2, 12);
			// quiet stretch with no idling on either side
			quiet <= (loads_sent >= 230 && loads_sent < 320);
			// one full drain of owed results before sending more
			if (!drained && loads_sent >= 150) begin
				drained = 1'b1;
				in_valid <= 1'b0;
				@(posedge clk);
				while (products_owed != 0)
					@(posedge clk);
			end
			for (int i = 0; i < run_len; i++)
				load_beat(random_element(), random_element(), $urandom_range(CELLS - 1),
					i == run_len - 1);
		end

		// wind down and wait for the last results
		in_valid <= 1'b0;
		@(posedge clk);
		while (products_owed != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d load beats in %0d multiply runs, %0d result beats (%0d clipped)",
			loads_sent, runs_sent, results_seen, clipped_seen);
		$display("random stalls on both sides, one quiet stretch, one full drain mid-run");
		if (mismatches == 0 && products_owed == 0)
			$display("PASS matrix4x4_multiply");
		else
			$display("FAIL matrix4x4_multiply");
		$finish;
	end

endmodule

// ----- sim.f -----
design/mm4_pkg.sv
design/mm4_ctrl.sv
design/mm4_dpath.sv
design/matrix4x4_multiply.sv
tb/sv/matrix4x4_multiply_checker.sv
tb/sv/tb_matrix4x4_multiply.sv
